// ===== hdl/sifb_pkg.sv =====
// Shared types and constants for the stuffed information frame builder.
// No dependencies; every other file in hdl/ except sifb_checker refers to this package.
`timescale 1ns / 1ps

package sifb_pkg;

   localparam int unsigned QUEUE_DEPTH = 2;

   localparam logic [7:0] STUFF_XOR = 8'h20;

   localparam int unsigned CSR_INDEX_W = 3;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FLAG     = 3'd0,
      CSR_ESCAPE   = 3'd1,
      CSR_ADDRESS  = 3'd2,
      CSR_CTL_ZERO = 3'd3,
      CSR_CTL_ONE  = 3'd4
   } csr_index_type;

   localparam logic [7:0] FLAG_RESET     = 8'h7E;
   localparam logic [7:0] ESCAPE_RESET   = 8'h7D;
   localparam logic [7:0] ADDRESS_RESET  = 8'h03;
   localparam logic [7:0] CTL_ZERO_RESET = 8'h00;
   localparam logic [7:0] CTL_ONE_RESET  = 8'h40;

   typedef struct packed {
      logic [7:0] flag_byte;
      logic [7:0] escape_byte;
      logic [7:0] address_byte;
      logic [7:0] control_seq_zero;
      logic [7:0] control_seq_one;
   } cfg_type;

   typedef struct packed {
      logic       hdr;
      logic [7:0] ctl;
      logic [7:0] data;
      logic       data_esc;
      logic       last;
      logic [7:0] chk;
      logic       chk_esc;
   } desc_type;

endpackage

// ===== hdl/sifb_csr.sv =====
// Configuration register file of the frame builder.
// Depends on sifb_pkg for the register index codes and reset values.
`timescale 1ns / 1ps

module sifb_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [sifb_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [7:0]                          csr_data,
   output sifb_pkg::cfg_type                   cfg
);

   sifb_pkg::cfg_type cfg_ff;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.flag_byte        <= sifb_pkg::FLAG_RESET;
         cfg_ff.escape_byte      <= sifb_pkg::ESCAPE_RESET;
         cfg_ff.address_byte     <= sifb_pkg::ADDRESS_RESET;
         cfg_ff.control_seq_zero <= sifb_pkg::CTL_ZERO_RESET;
         cfg_ff.control_seq_one  <= sifb_pkg::CTL_ONE_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            sifb_pkg::CSR_FLAG:     cfg_ff.flag_byte        <= csr_data;
            sifb_pkg::CSR_ESCAPE:   cfg_ff.escape_byte      <= csr_data;
            sifb_pkg::CSR_ADDRESS:  cfg_ff.address_byte     <= csr_data;
            sifb_pkg::CSR_CTL_ZERO: cfg_ff.control_seq_zero <= csr_data;
            sifb_pkg::CSR_CTL_ONE:  cfg_ff.control_seq_one  <= csr_data;
            default: ;
         endcase
      end
   end

endmodule

// ===== hdl/sifb_front.sv =====
// Front end: accepts payload requests, tracks frame state and check byte,
// and classifies each request into a descriptor. Depends on sifb_pkg.
`timescale 1ns / 1ps

module sifb_front (
   input  logic                 clock,
   input  logic                 reset,
   input  sifb_pkg::cfg_type    cfg,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [7:0]           req_data_byte,
   input  logic                 req_last_byte,
   input  logic                 req_seq_bit,
   input  logic                 q_full,
   output logic                 q_push,
   output sifb_pkg::desc_type   q_desc
);

   logic       in_frame_ff;
   logic       in_frame_in;
   logic [7:0] accum_ff;
   logic [7:0] accum_in;
   logic [7:0] chk;

   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;

   always_comb begin
      chk = (in_frame_ff ? accum_ff : 8'h00) ^ req_data_byte;

      q_desc.hdr      = !in_frame_ff;
      q_desc.ctl      = req_seq_bit ? cfg.control_seq_one : cfg.control_seq_zero;
      q_desc.data     = req_data_byte;
      q_desc.data_esc = (req_data_byte == cfg.flag_byte) ||
                        (req_data_byte == cfg.escape_byte);
      q_desc.last     = req_last_byte;
      q_desc.chk      = chk;
      q_desc.chk_esc  = (chk == cfg.flag_byte) || (chk == cfg.escape_byte);

      in_frame_in = in_frame_ff;
      accum_in    = accum_ff;
      if (q_push) begin
         in_frame_in = !req_last_byte;
         accum_in    = req_last_byte ? 8'h00 : chk;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff <= 1'b0;
         accum_ff    <= 8'h00;
      end else begin
         in_frame_ff <= in_frame_in;
         accum_ff    <= accum_in;
      end
   end

endmodule

// ===== hdl/sifb_queue.sv =====
// Descriptor queue between front end and back end.
// Depends on sifb_pkg for the descriptor type.
`timescale 1ns / 1ps

module sifb_queue #(
   parameter int unsigned DEPTH = sifb_pkg::QUEUE_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  sifb_pkg::desc_type   push_desc,
   output logic                 full,
   input  logic                 pop,
   output logic                 empty,
   output sifb_pkg::desc_type   head
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   sifb_pkg::desc_type mem [DEPTH];

   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             do_push;
   logic             do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign head    = mem[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_desc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

// ===== hdl/sifb_back.sv =====
// Back end: steps through each descriptor and emits one frame byte per
// cycle into the response register while not stalled. Depends on sifb_pkg.
`timescale 1ns / 1ps

module sifb_back (
   input  logic                 clock,
   input  logic                 reset,
   input  sifb_pkg::cfg_type    cfg,
   input  logic                 q_empty,
   input  sifb_pkg::desc_type   q_head,
   output logic                 q_pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [7:0]           rsp_out_byte,
   output logic                 rsp_run_last,
   output logic                 rsp_frame_end
);

   typedef enum logic [3:0] {
      ST_FLAG,
      ST_ADDR,
      ST_CTL,
      ST_HCHK,
      ST_DESC,
      ST_DATA,
      ST_CESC,
      ST_CHK,
      ST_CLOSE
   } step_type;

   sifb_pkg::desc_type cur_ff;
   step_type           step_ff;
   step_type           step_in;
   step_type           first_step;
   logic               busy_ff;
   logic               load;
   logic               done;
   logic [7:0]         byte_in;
   logic               run_last_in;
   logic               frame_end_in;

   logic       rsp_valid_ff;
   logic [7:0] rsp_out_byte_ff;
   logic       rsp_run_last_ff;
   logic       rsp_frame_end_ff;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_byte  = rsp_out_byte_ff;
   assign rsp_run_last  = rsp_run_last_ff;
   assign rsp_frame_end = rsp_frame_end_ff;

   assign load  = !rsp_valid_ff || !rsp_stall;
   assign q_pop = load && (!busy_ff || done) && !q_empty;

   always_comb begin
      if (q_head.hdr) begin
         first_step = ST_FLAG;
      end else if (q_head.data_esc) begin
         first_step = ST_DESC;
      end else begin
         first_step = ST_DATA;
      end

      byte_in      = cur_ff.data;
      run_last_in  = 1'b0;
      frame_end_in = 1'b0;
      done         = 1'b0;
      step_in      = step_ff;
      unique case (step_ff)
         ST_FLAG: begin
            byte_in = cfg.flag_byte;
            step_in = ST_ADDR;
         end
         ST_ADDR: begin
            byte_in = cfg.address_byte;
            step_in = ST_CTL;
         end
         ST_CTL: begin
            byte_in = cur_ff.ctl;
            step_in = ST_HCHK;
         end
         ST_HCHK: begin
            byte_in = cfg.address_byte ^ cur_ff.ctl;
            step_in = cur_ff.data_esc ? ST_DESC : ST_DATA;
         end
         ST_DESC: begin
            byte_in = cfg.escape_byte;
            step_in = ST_DATA;
         end
         ST_DATA: begin
            byte_in     = cur_ff.data_esc ? (cur_ff.data ^ sifb_pkg::STUFF_XOR)
                                          : cur_ff.data;
            run_last_in = !cur_ff.last;
            done        = !cur_ff.last;
            step_in     = cur_ff.chk_esc ? ST_CESC : ST_CHK;
         end
         ST_CESC: begin
            byte_in = cfg.escape_byte;
            step_in = ST_CHK;
         end
         ST_CHK: begin
            byte_in = cur_ff.chk_esc ? (cur_ff.chk ^ sifb_pkg::STUFF_XOR)
                                     : cur_ff.chk;
            step_in = ST_CLOSE;
         end
         ST_CLOSE: begin
            byte_in      = cfg.flag_byte;
            run_last_in  = 1'b1;
            frame_end_in = 1'b1;
            done         = 1'b1;
         end
         default: begin
            done = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         step_ff      <= ST_FLAG;
         rsp_valid_ff <= 1'b0;
      end else if (load) begin
         rsp_valid_ff     <= busy_ff;
         rsp_out_byte_ff  <= byte_in;
         rsp_run_last_ff  <= run_last_in;
         rsp_frame_end_ff <= frame_end_in;
         if (busy_ff && !done) begin
            step_ff <= step_in;
         end else if (!q_empty) begin
            cur_ff  <= q_head;
            step_ff <= first_step;
            busy_ff <= 1'b1;
         end else begin
            busy_ff <= 1'b0;
         end
      end
   end

endmodule

// ===== hdl/stuffed_info_frame_builder_core.sv =====
// Top level of the stuffed information frame builder.
// Instantiates sifb_csr, sifb_front, sifb_queue and sifb_back; uses sifb_pkg.
`timescale 1ns / 1ps

// Each payload request turns into one to nine frame bytes on the response
// channel: a four-byte header on the first byte of a frame, one or two bytes
// for the stuffed payload byte, and on the last byte the stuffed check byte
// and a closing flag. The back-end sequencer emits one response per cycle
// while it has a descriptor and the response channel is not stalled, so a
// request holds the back end for one step per byte it produces. Requests are
// taken every cycle while the descriptor queue (QUEUE_DEPTH entries) has
// room; a request passes through a queue entry and the back end's current
// descriptor register before its first byte reaches the response register.
// Write the csr registers only while no frame bytes are pending.

module stuffed_info_frame_builder_core #(
   parameter int unsigned QUEUE_DEPTH = sifb_pkg::QUEUE_DEPTH
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [7:0]                        req_data_byte,
   input  logic                              req_last_byte,
   input  logic                              req_seq_bit,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [7:0]                        rsp_out_byte,
   output logic                              rsp_run_last,
   output logic                              rsp_frame_end,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [sifb_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [7:0]                        csr_data
);

   sifb_pkg::cfg_type  cfg;
   sifb_pkg::desc_type push_desc;
   sifb_pkg::desc_type head;
   logic               push;
   logic               full;
   logic               pop;
   logic               empty;

   sifb_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   sifb_front u_front (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .req_seq_bit   (req_seq_bit),
      .q_full        (full),
      .q_push        (push),
      .q_desc        (push_desc)
   );

   sifb_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_desc (push_desc),
      .full      (full),
      .pop       (pop),
      .empty     (empty),
      .head      (head)
   );

   sifb_back u_back (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .q_empty       (empty),
      .q_head        (head),
      .q_pop         (pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_run_last  (rsp_run_last),
      .rsp_frame_end (rsp_frame_end)
   );

endmodule

// ===== hdl/sifb_checker.sv =====
// Port-level checks for stuffed_info_frame_builder_core, bound to the top.
// Sees only the top level's handshake and response ports.
`timescale 1ns / 1ps

module sifb_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_stall,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic [7:0]                        rsp_out_byte,
   input logic                              rsp_run_last,
   input logic                              rsp_frame_end
);

   a_end_is_run_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_end |-> rsp_run_last)
      else $error("closing flag without run_last");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_byte) &&
                                 $stable(rsp_run_last) && $stable(rsp_frame_end))
      else $error("stalled response changed");

   a_no_back_to_back_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_end && !rsp_stall |=> !(rsp_valid && rsp_frame_end))
      else $error("two closing flags in a row");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_stall_needs_backlog: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |-> rsp_valid)
      else $error("request stalled with empty response register");

endmodule

bind stuffed_info_frame_builder_core sifb_checker u_sifb_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_out_byte  (rsp_out_byte),
   .rsp_run_last  (rsp_run_last),
   .rsp_frame_end (rsp_frame_end)
);

// ===== tb/sv/tb.sv =====
// Self-checking regression for stuffed_info_frame_builder_core.
// Predicts frame bytes from payload requests and csr writes; uses sifb_pkg.
`timescale 1ns / 1ps

module tb;

   localparam int unsigned CYCLE_LIMIT  = 200000;
   localparam int unsigned DRAIN_CYCLES = 6;
   localparam logic [sifb_pkg::CSR_INDEX_W-1:0] CSR_SPARE_FIVE  = 3'd5;
   localparam logic [sifb_pkg::CSR_INDEX_W-1:0] CSR_SPARE_SEVEN = 3'd7;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
      logic       seq_bit;
   } payload_req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_last;
      logic       frame_end;
   } frame_byte_type;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_valid = 1'b0;
   logic                             req_stall;
   logic [7:0]                       req_data_byte = 8'h00;
   logic                             req_last_byte = 1'b0;
   logic                             req_seq_bit = 1'b0;
   logic                             rsp_valid;
   logic                             rsp_stall = 1'b0;
   logic [7:0]                       rsp_out_byte;
   logic                             rsp_run_last;
   logic                             rsp_frame_end;
   logic                             csr_valid = 1'b0;
   logic                             csr_ready;
   logic [sifb_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [7:0]                       csr_data = 8'h00;

   payload_req_type pending_requests[$];
   frame_byte_type  frame_bytes_due[$];
   logic [7:0]      scratch_bytes[$];
   logic            scratch_ends[$];

   sifb_pkg::cfg_type shadow_cfg;
   logic [7:0]        running_check;
   logic              open_frame;

   int unsigned pushed_count = 0;
   int unsigned accepted_count = 0;
   int unsigned error_count = 0;
   int unsigned cycle_count = 0;
   logic        req_taken = 1'b0;
   int unsigned gap_left = 0;
   int unsigned burst_left = 0;
   int unsigned stall_mode = 0;
   int unsigned stall_left = 0;
   int unsigned stall_phase = 0;

   stuffed_info_frame_builder_core dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .req_seq_bit   (req_seq_bit),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_run_last  (rsp_run_last),
      .rsp_frame_end (rsp_frame_end),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("stuffed_info_frame_builder_core regression: fail");
         $finish;
      end
   end

   task automatic emit_byte(input logic [7:0] b, input logic frame_end);
      scratch_bytes.push_back(b);
      scratch_ends.push_back(frame_end);
   endtask

   task automatic emit_stuffed(input logic [7:0] b);
      if (b == shadow_cfg.flag_byte || b == shadow_cfg.escape_byte) begin
         emit_byte(shadow_cfg.escape_byte, 1'b0);
         emit_byte(b ^ sifb_pkg::STUFF_XOR, 1'b0);
      end else begin
         emit_byte(b, 1'b0);
      end
   endtask

   task automatic predict_frame_bytes(input payload_req_type r);
      logic [7:0]     ctl;
      frame_byte_type fb;
      scratch_bytes.delete();
      scratch_ends.delete();
      if (!open_frame) begin
         ctl = r.seq_bit ? shadow_cfg.control_seq_one : shadow_cfg.control_seq_zero;
         emit_byte(shadow_cfg.flag_byte, 1'b0);
         emit_byte(shadow_cfg.address_byte, 1'b0);
         emit_byte(ctl, 1'b0);
         emit_byte(shadow_cfg.address_byte ^ ctl, 1'b0);
         running_check = 8'h00;
         open_frame = 1'b1;
      end
      emit_stuffed(r.data_byte);
      running_check = running_check ^ r.data_byte;
      if (r.last_byte) begin
         emit_stuffed(running_check);
         emit_byte(shadow_cfg.flag_byte, 1'b1);
         running_check = 8'h00;
         open_frame = 1'b0;
      end
      for (int i = 0; i < scratch_bytes.size(); i++) begin
         fb.out_byte  = scratch_bytes[i];
         fb.frame_end = scratch_ends[i];
         fb.run_last  = (i == scratch_bytes.size() - 1);
         frame_bytes_due.push_back(fb);
      end
   endtask

   // monitor: requests in, frame bytes out
   always @(posedge clock) begin
      frame_byte_type want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            predict_frame_bytes('{req_data_byte, req_last_byte, req_seq_bit});
            accepted_count++;
            req_taken = 1'b1;
         end
         if (rsp_valid && !rsp_stall) begin
            if (frame_bytes_due.size() == 0) begin
               $error("unexpected frame byte %h", rsp_out_byte);
               error_count++;
            end else begin
               want = frame_bytes_due.pop_front();
               if (rsp_out_byte !== want.out_byte) begin
                  $error("out_byte expected %h actual %h", want.out_byte, rsp_out_byte);
                  error_count++;
               end
               if (rsp_run_last !== want.run_last) begin
                  $error("run_last expected %b actual %b", want.run_last, rsp_run_last);
                  error_count++;
               end
               if (rsp_frame_end !== want.frame_end) begin
                  $error("frame_end expected %b actual %b", want.frame_end, rsp_frame_end);
                  error_count++;
               end
            end
         end
      end
   end

   // driver: bursts of requests with random gaps
   always @(negedge clock) begin
      payload_req_type r;
      logic            hold;
      hold = req_valid && !req_taken;
      req_taken = 1'b0;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!hold) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_requests.size() > 0) begin
            r = pending_requests.pop_front();
            req_valid     <= 1'b1;
            req_data_byte <= r.data_byte;
            req_last_byte <= r.last_byte;
            req_seq_bit   <= r.seq_bit;
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 16);
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver stall pattern
   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_left = $urandom_range(20, 80);
      end
      stall_left--;
      stall_phase++;
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         2: rsp_stall <= ($urandom_range(0, 3) != 0);
         default: rsp_stall <= (stall_phase % 3 == 0);
      endcase
   end

   task automatic write_reg(input logic [sifb_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [7:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      case (idx)
         sifb_pkg::CSR_FLAG:     shadow_cfg.flag_byte        = value;
         sifb_pkg::CSR_ESCAPE:   shadow_cfg.escape_byte      = value;
         sifb_pkg::CSR_ADDRESS:  shadow_cfg.address_byte     = value;
         sifb_pkg::CSR_CTL_ZERO: shadow_cfg.control_seq_zero = value;
         sifb_pkg::CSR_CTL_ONE:  shadow_cfg.control_seq_one  = value;
         default: ;
      endcase
   endtask

   task automatic load_config(input logic [7:0] flag, input logic [7:0] esc,
                              input logic [7:0] addr, input logic [7:0] ctl0,
                              input logic [7:0] ctl1);
      write_reg(sifb_pkg::CSR_FLAG, flag);
      write_reg(sifb_pkg::CSR_ESCAPE, esc);
      write_reg(sifb_pkg::CSR_ADDRESS, addr);
      write_reg(sifb_pkg::CSR_CTL_ZERO, ctl0);
      write_reg(sifb_pkg::CSR_CTL_ONE, ctl1);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic queue_request(input logic [7:0] data, input logic last, input logic seq);
      pending_requests.push_back('{data, last, seq});
      pushed_count++;
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (accepted_count != pushed_count || frame_bytes_due.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic queue_random_frames(input int unsigned item_goal);
      int unsigned n;
      int unsigned len;
      logic [7:0]  b;
      n = 0;
      while (n < item_goal) begin
         len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 20) : $urandom_range(1, 6);
         for (int unsigned i = 0; i < len; i++) begin
            case ($urandom_range(0, 9))
               0, 1:    b = shadow_cfg.flag_byte;
               2:       b = shadow_cfg.escape_byte;
               3:       b = shadow_cfg.flag_byte ^ sifb_pkg::STUFF_XOR;
               4:       b = shadow_cfg.escape_byte ^ sifb_pkg::STUFF_XOR;
               default: b = 8'($urandom_range(0, 255));
            endcase
            queue_request(b, i == len - 1, 1'($urandom_range(0, 1)));
         end
         n += len;
      end
   endtask

   initial begin
      logic [7:0] f;
      shadow_cfg = '{sifb_pkg::FLAG_RESET, sifb_pkg::ESCAPE_RESET, sifb_pkg::ADDRESS_RESET,
                     sifb_pkg::CTL_ZERO_RESET, sifb_pkg::CTL_ONE_RESET};
      running_check = 8'h00;
      open_frame = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: single-byte frames, escaped check bytes, seq ignored mid-frame
      queue_request(8'h7E, 1'b1, 1'b1);
      queue_request(8'h7D, 1'b1, 1'b0);
      queue_request(8'h7D, 1'b0, 1'b0);
      queue_request(8'h00, 1'b0, 1'b1);
      queue_request(8'hFF, 1'b1, 1'b0);
      queue_request(8'h10, 1'b0, 1'b1);
      queue_request(8'h6E, 1'b1, 1'b0);
      queue_request(8'h5E, 1'b0, 1'b0);
      queue_request(8'h5D, 1'b0, 1'b1);
      queue_request(8'h7E, 1'b1, 1'b1);
      wait_idle();

      // flag equal to escape, spare indices ignored
      write_reg(CSR_SPARE_FIVE, 8'hA5);
      write_reg(CSR_SPARE_SEVEN, 8'h5A);
      load_config(8'h00, 8'h00, 8'hFF, 8'hFF, 8'h00);
      queue_request(8'h00, 1'b1, 1'b0);
      queue_request(8'h20, 1'b0, 1'b1);
      queue_request(8'h00, 1'b0, 1'b0);
      queue_request(8'h20, 1'b1, 1'b1);
      queue_request(8'hFF, 1'b1, 1'b1);
      wait_idle();

      // opposite extremes
      load_config(8'hFF, 8'h00, 8'h00, 8'h00, 8'hFF);
      queue_request(8'hFF, 1'b1, 1'b1);
      queue_request(8'h00, 1'b0, 1'b0);
      queue_request(8'hDF, 1'b0, 1'b1);
      queue_request(8'h20, 1'b1, 1'b0);
      queue_request(8'h01, 1'b0, 1'b1);
      queue_request(8'hFE, 1'b1, 1'b1);
      wait_idle();

      for (int p = 0; p < 6; p++) begin
         f = 8'($urandom_range(0, 255));
         if (p == 0)
            load_config(sifb_pkg::FLAG_RESET, sifb_pkg::ESCAPE_RESET,
                        sifb_pkg::ADDRESS_RESET, sifb_pkg::CTL_ZERO_RESET,
                        sifb_pkg::CTL_ONE_RESET);
         else
            load_config(f, ($urandom_range(0, 3) == 0) ? f : 8'($urandom_range(0, 255)),
                        8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                        8'($urandom_range(0, 255)));
         queue_random_frames(45);
         wait_idle();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (frame_bytes_due.size() != 0) begin
         $error("frame bytes still expected: %0d", frame_bytes_due.size());
         error_count++;
      end
      if (error_count == 0)
         $display("stuffed_info_frame_builder_core regression: pass");
      else
         $display("stuffed_info_frame_builder_core regression: fail");
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/sifb_pkg.sv
hdl/sifb_csr.sv
hdl/sifb_front.sv
hdl/sifb_queue.sv
hdl/sifb_back.sv
hdl/stuffed_info_frame_builder_core.sv
hdl/sifb_checker.sv
tb/sv/tb.sv
